[hdl/dead_man_button_debouncer_defines.svh]
// Assertion macros shared by the dead-man button debouncer checkers.
// Depends on nothing; included by the checker file.
`ifndef DEAD_MAN_BUTTON_DEBOUNCER_DEFINES_SVH
`define DEAD_MAN_BUTTON_DEBOUNCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dmbd_pkg.sv]
// Types, constants and helper functions of the dead-man button debouncer.
// Depends on nothing; used by the interfaces, the lane and the top level.
package dmbd_pkg;

    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int MASK_W   = 6;
    localparam int CFG_IDX_W = 8;

    localparam logic [MASK_W-1:0] OUT_MASK = 6'h3F;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPRESS_GUARD  = 8'd1;

    localparam logic [CFG_W-1:0] PRESS_DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] REPRESS_GUARD_RST  = 16'd50;

    typedef logic [TIME_W-1:0] t_time;

    typedef struct packed {
        logic [CFG_W-1:0] press_debounce_ms;
        logic [CFG_W-1:0] repress_guard_ms;
    } t_cfg;

    // True when (now - since) modulo 2^32 is at least limit.
    function automatic logic elapsed_ge(input t_time now, input t_time since,
                                        input logic [CFG_W-1:0] limit);
        t_time diff;
        diff = now - since;
        return (|diff[TIME_W-1:CFG_W]) || (diff[CFG_W-1:0] >= limit);
    endfunction

endpackage

[hdl/dmbd_if.sv]
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on dmbd_pkg for field widths.
interface dmbd_in_if;
    logic                         valid;
    logic                         ready;
    logic [dmbd_pkg::TIME_W-1:0]  now_ms;
    logic [dmbd_pkg::MASK_W-1:0]  pressed_bits;
    modport source (output valid, output now_ms, output pressed_bits, input ready);
    modport sink   (input valid, input now_ms, input pressed_bits, output ready);
endinterface

interface dmbd_out_if;
    logic                         valid;
    logic                         ready;
    logic [dmbd_pkg::MASK_W-1:0]  stable_mask;
    logic                         mask_changed;
    modport source (output valid, output stable_mask, output mask_changed, input ready);
    modport sink   (input valid, input stable_mask, input mask_changed, output ready);
endinterface

interface dmbd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dmbd_pkg::CFG_IDX_W-1:0] index;
    logic [dmbd_pkg::CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/dmbd_lane.sv]
// One button of the debouncer: raw and stable levels plus change and release times.
// Depends on dmbd_pkg for the time type, the register struct and elapsed_ge.
module dmbd_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  dmbd_pkg::t_time     i_now,
    input  logic                i_pressed,
    input  dmbd_pkg::t_cfg      i_cfg,
    output logic                o_stable,
    output logic                o_stable_next
);

    logic            r_raw, n_raw;
    logic            r_stable, n_stable;
    dmbd_pkg::t_time r_change, n_change;
    dmbd_pkg::t_time r_release, n_release;

    always_comb begin
        n_raw     = r_raw;
        n_stable  = r_stable;
        n_change  = r_change;
        n_release = r_release;
        if (r_stable) begin
            if (!i_pressed) begin
                n_stable  = 1'b0;
                n_raw     = 1'b0;
                n_change  = i_now;
                n_release = i_now;
            end
        end else begin
            n_raw = i_pressed;
            if (i_pressed != r_raw) begin
                n_change = i_now;
            end
            if (i_pressed) begin
                n_stable = dmbd_pkg::elapsed_ge(i_now, r_release, i_cfg.repress_guard_ms)
                        && dmbd_pkg::elapsed_ge(i_now, n_change, i_cfg.press_debounce_ms);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw     <= 1'b0;
            r_stable  <= 1'b0;
            r_change  <= '0;
            r_release <= '0;
        end else if (i_en) begin
            r_raw     <= n_raw;
            r_stable  <= n_stable;
            r_change  <= n_change;
            r_release <= n_release;
        end
    end

    assign o_stable      = r_stable;
    assign o_stable_next = n_stable;

endmodule

[hdl/dead_man_button_debouncer.sv]
// Top level of the dead-man button debouncer: input register, button lanes, result register.
// Depends on dmbd_pkg, the channel interfaces and dmbd_lane.
//
//   channel   modport  moves                             accepted when
//   i_in      sink     now_ms, pressed_bits              valid && ready
//   o_out     source   stable_mask, mask_changed         valid && ready
//   i_cfg     sink     index, data (register write)      valid && ready
//
// One item per cycle unless the result stalls; a sample is accepted into the input register,
// and its result is presented when the lane logic loads the result register from it.
// Every button is handled in parallel by two subtracts of 32-bit times, each compared to a 16-bit limit.
// Reset (synchronous, active low) releases every button at time 0 and restores the registers.
// A stalled result holds the result register; the input register still takes one more item.
// Register writes are always ready.
module dead_man_button_debouncer #(
    parameter int NUM_BUTTONS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmbd_in_if.sink     i_in,
    dmbd_out_if.source  o_out,
    dmbd_cfg_if.sink    i_cfg
);

    localparam int LANES = (NUM_BUTTONS < dmbd_pkg::MASK_W) ? NUM_BUTTONS : dmbd_pkg::MASK_W;

    dmbd_pkg::t_cfg               r_cfg;
    logic                         r_in_valid;
    dmbd_pkg::t_time              r_now;
    logic [dmbd_pkg::MASK_W-1:0]  r_bits;
    logic                         r_out_valid;
    logic [dmbd_pkg::MASK_W-1:0]  r_mask;
    logic                         r_changed;

    logic                         w_adv;
    logic [dmbd_pkg::MASK_W-1:0]  w_cur_mask;
    logic [dmbd_pkg::MASK_W-1:0]  n_mask;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    for (genvar g = 0; g < dmbd_pkg::MASK_W; g++) begin : g_lane
        if (g < LANES) begin : g_used
            dmbd_lane u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_en          (w_adv),
                .i_now         (r_now),
                .i_pressed     (r_bits[g]),
                .i_cfg         (r_cfg),
                .o_stable      (w_cur_mask[g]),
                .o_stable_next (n_mask[g])
            );
        end else begin : g_unused
            assign w_cur_mask[g] = 1'b0;
            assign n_mask[g]     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_debounce_ms <= dmbd_pkg::PRESS_DEBOUNCE_RST;
            r_cfg.repress_guard_ms  <= dmbd_pkg::REPRESS_GUARD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dmbd_pkg::REG_PRESS_DEBOUNCE: r_cfg.press_debounce_ms <= i_cfg.data;
                dmbd_pkg::REG_REPRESS_GUARD:  r_cfg.repress_guard_ms  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_now  <= i_in.now_ms;
            r_bits <= i_in.pressed_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mask    <= n_mask & dmbd_pkg::OUT_MASK;
            r_changed <= (n_mask != w_cur_mask);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.stable_mask  = r_mask;
    assign o_out.mask_changed = r_changed;

endmodule

[hdl/dmbd_checker.sv]
// Port-level checks of the dead-man button debouncer, bound to its top level.
// Depends on dmbd_pkg and the assertion macros in the defines header.
`include "dead_man_button_debouncer_defines.svh"

module dmbd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dmbd_pkg::MASK_W-1:0] i_out_mask,
    input logic                        i_out_changed
);

    logic                        w_in_acc;
    logic                        w_out_acc;
    logic [dmbd_pkg::MASK_W-1:0] r_last_mask;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mask <= '0;
        end else if (w_out_acc) begin
            r_last_mask <= i_out_mask;
        end
    end

    `DMBD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_mask) && $stable(i_out_changed), "stalled result changed")
    `DMBD_ASSERT_NOW(a_changed_flag, i_clk, i_rst_n, w_out_acc, i_out_changed == (i_out_mask != r_last_mask), "change flag disagrees with delivered masks")
    `DMBD_ASSERT_NOW(a_result_source, i_clk, i_rst_n, $rose(i_out_valid), $past(w_in_acc, 2), "result without a sample two cycles earlier")

endmodule

bind dead_man_button_debouncer dmbd_checker u_dmbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_mask    (o_out.stable_mask),
    .i_out_changed (o_out.mask_changed)
);
